### design/hpg_pkg.sv
package hpg_pkg;

    localparam int INDEX_BITS  = 16;
    localparam int FRAC_BITS   = 24;
    localparam int COUNT_BITS  = INDEX_BITS + 1;
    localparam int BASE_BITS   = 5;
    localparam int DEN_BITS    = INDEX_BITS + BASE_BITS;
    localparam int QUO_BITS    = (INDEX_BITS > FRAC_BITS) ? INDEX_BITS : FRAC_BITS;
    localparam int CNT_BITS    = $clog2(QUO_BITS);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] POINT_COUNT_RST = COUNT_BITS'(256);
    localparam logic [BASE_BITS-1:0]  BASE_SECOND_RST = BASE_BITS'(2);
    localparam logic [BASE_BITS-1:0]  BASE_THIRD_RST  = BASE_BITS'(3);
    localparam logic [BASE_BITS-1:0]  BASE_MIN        = BASE_BITS'(2);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POINT_COUNT = 2'd0,
        CFG_BASE_SECOND = 2'd1,
        CFG_BASE_THIRD  = 2'd2
    } t_cfg_index;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_DIGIT = 7'b0001000,
        S_ACCUM = 7'b0010000,
        S_FRAC  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

endpackage

### design/hpg_div_unit.sv
module hpg_div_unit
    import hpg_pkg::*;
(
    input  logic                i_clk,
    input  t_div_ctrl           i_ctrl,
    input  logic [DEN_BITS-1:0] i_rem,
    input  logic [QUO_BITS-1:0] i_quo,
    input  logic [DEN_BITS-1:0] i_div,
    output logic [DEN_BITS-1:0] o_rem,
    output logic [QUO_BITS-1:0] o_quo
);

    logic [DEN_BITS-1:0] r_rem, n_rem;
    logic [QUO_BITS-1:0] r_quo, n_quo;
    logic [DEN_BITS-1:0] r_div, n_div;
    logic [DEN_BITS:0]   w_trial;
    logic [DEN_BITS:0]   w_diff;
    logic                w_ge;

    assign w_trial = {r_rem, r_quo[QUO_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_div = r_div;
        if (i_ctrl.load) begin
            n_rem = i_rem;
            n_quo = i_quo;
            n_div = i_div;
        end else if (i_ctrl.step) begin
            n_rem = w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
            n_quo = {r_quo[QUO_BITS-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

### design/hammersley_point_generator_core.sv
// Channel   Direction  Handshake                    Beat contents
// in        in         i_in_valid / o_in_ready      i_point_index
// out       out        o_out_valid / i_out_ready    o_coord_first, o_coord_second,
//                                                   o_coord_third, o_index_beyond_count
// cfg       in         i_cfg_wr_en (no wait)        i_cfg_index, i_cfg_wdata
//
// One restoring divider, one quotient bit a cycle, serves every division.
// Per beat: index / count gives the first coordinate unless index >= count; per base,
// a setup, divide + accumulate per digit, a fraction divide; index zero has no digits.
// Synchronous active-low reset restores count 256, bases 2 and 3, and empties the output.
// A held output beat does not stall the next input beat; only the final copy waits.
module hammersley_point_generator_core
    import hpg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [INDEX_BITS-1:0]    i_point_index,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [FRAC_BITS-1:0]     o_coord_first,
    output logic [FRAC_BITS-1:0]     o_coord_second,
    output logic [FRAC_BITS-1:0]     o_coord_third,
    output logic                     o_index_beyond_count,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_wdata
);

    localparam int PROD_BITS = DEN_BITS + BASE_BITS;

    t_state                r_state, n_state;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_pass, n_pass;
    logic [INDEX_BITS-1:0] r_idx, n_idx;
    logic                  r_beyond, n_beyond;
    logic [FRAC_BITS-1:0]  r_first, n_first;
    logic [FRAC_BITS-1:0]  r_second, n_second;
    logic [FRAC_BITS-1:0]  r_third, n_third;
    logic [DEN_BITS-1:0]   r_num, n_num;
    logic [DEN_BITS-1:0]   r_den, n_den;
    logic [BASE_BITS-1:0]  r_base, n_base;
    logic [COUNT_BITS-1:0] r_point_count;
    logic [BASE_BITS-1:0]  r_base_second;
    logic [BASE_BITS-1:0]  r_base_third;
    logic                  r_out_valid, n_out_valid;
    logic [FRAC_BITS-1:0]  r_out_first, n_out_first;
    logic [FRAC_BITS-1:0]  r_out_second, n_out_second;
    logic [FRAC_BITS-1:0]  r_out_third, n_out_third;
    logic                  r_out_beyond, n_out_beyond;

    t_div_ctrl             w_div_ctrl;
    logic [DEN_BITS-1:0]   w_div_rem_ld;
    logic [QUO_BITS-1:0]   w_div_quo_ld;
    logic [DEN_BITS-1:0]   w_div_div_ld;
    logic [DEN_BITS-1:0]   w_div_rem;
    logic [QUO_BITS-1:0]   w_div_quo;

    logic                  w_beyond;
    logic [BASE_BITS-1:0]  w_base_cfg;
    logic [BASE_BITS-1:0]  w_base_eff;
    logic [INDEX_BITS-1:0] w_quot;
    logic [PROD_BITS-1:0]  w_num_prod;
    logic [PROD_BITS-1:0]  w_den_prod;

    hpg_div_unit u_div (
        .i_clk  (i_clk),
        .i_ctrl (w_div_ctrl),
        .i_rem  (w_div_rem_ld),
        .i_quo  (w_div_quo_ld),
        .i_div  (w_div_div_ld),
        .o_rem  (w_div_rem),
        .o_quo  (w_div_quo)
    );

    assign w_beyond   = COUNT_BITS'(i_point_index) >= r_point_count;
    assign w_base_cfg = r_pass ? r_base_third : r_base_second;
    assign w_base_eff = (w_base_cfg < BASE_MIN) ? BASE_MIN : w_base_cfg;
    assign w_quot     = w_div_quo[INDEX_BITS-1:0];
    assign w_num_prod = PROD_BITS'(r_num) * PROD_BITS'(r_base)
                      + PROD_BITS'(w_div_rem[BASE_BITS-1:0]);
    assign w_den_prod = PROD_BITS'(r_den) * PROD_BITS'(r_base);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pass       = r_pass;
        n_idx        = r_idx;
        n_beyond     = r_beyond;
        n_first      = r_first;
        n_second     = r_second;
        n_third      = r_third;
        n_num        = r_num;
        n_den        = r_den;
        n_base       = r_base;
        n_out_valid  = r_out_valid;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_third  = r_out_third;
        n_out_beyond = r_out_beyond;
        w_div_ctrl   = '0;
        w_div_rem_ld = '0;
        w_div_quo_ld = '0;
        w_div_div_ld = '0;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx    = i_point_index;
                    n_beyond = w_beyond;
                    n_pass   = 1'b0;
                    n_cnt    = '0;
                    if (w_beyond) begin
                        n_first = '1;
                        n_state = S_SETUP;
                    end else begin
                        w_div_ctrl.load = 1'b1;
                        w_div_rem_ld    = DEN_BITS'(i_point_index);
                        w_div_div_ld    = DEN_BITS'(r_point_count);
                        n_state         = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                w_div_ctrl.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(FRAC_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (!r_pass && !r_beyond) begin
                    n_first = w_div_quo[FRAC_BITS-1:0];
                end
                n_num           = '0;
                n_den           = DEN_BITS'(1);
                n_base          = w_base_eff;
                n_cnt           = '0;
                w_div_ctrl.load = 1'b1;
                if (r_idx == '0) begin
                    w_div_div_ld = DEN_BITS'(1);
                    n_state      = S_FRAC;
                end else begin
                    w_div_quo_ld = QUO_BITS'(r_idx) << (QUO_BITS - INDEX_BITS);
                    w_div_div_ld = DEN_BITS'(w_base_eff);
                    n_state      = S_DIGIT;
                end
            end
            S_DIGIT: begin
                w_div_ctrl.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(INDEX_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ACCUM;
                end
            end
            S_ACCUM: begin
                n_num           = w_num_prod[DEN_BITS-1:0];
                n_den           = w_den_prod[DEN_BITS-1:0];
                w_div_ctrl.load = 1'b1;
                if (w_quot == '0) begin
                    w_div_rem_ld = w_num_prod[DEN_BITS-1:0];
                    w_div_div_ld = w_den_prod[DEN_BITS-1:0];
                    n_state      = S_FRAC;
                end else begin
                    w_div_quo_ld = QUO_BITS'(w_quot) << (QUO_BITS - INDEX_BITS);
                    w_div_div_ld = DEN_BITS'(r_base);
                    n_state      = S_DIGIT;
                end
            end
            S_FRAC: begin
                w_div_ctrl.step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(FRAC_BITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_pass) begin
                    n_second = w_div_quo[FRAC_BITS-1:0];
                    n_pass   = 1'b1;
                    n_state  = S_SETUP;
                end else if (!r_out_valid || i_out_ready) begin
                    n_third      = w_div_quo[FRAC_BITS-1:0];
                    n_out_first  = r_first;
                    n_out_second = r_second;
                    n_out_third  = w_div_quo[FRAC_BITS-1:0];
                    n_out_beyond = r_beyond;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_pass        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_point_count <= POINT_COUNT_RST;
            r_base_second <= BASE_SECOND_RST;
            r_base_third  <= BASE_THIRD_RST;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_POINT_COUNT: r_point_count <= i_cfg_wdata;
                    CFG_BASE_SECOND: r_base_second <= i_cfg_wdata[BASE_BITS-1:0];
                    CFG_BASE_THIRD:  r_base_third  <= i_cfg_wdata[BASE_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_beyond     <= n_beyond;
        r_first      <= n_first;
        r_second     <= n_second;
        r_third      <= n_third;
        r_num        <= n_num;
        r_den        <= n_den;
        r_base       <= n_base;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_third  <= n_out_third;
        r_out_beyond <= n_out_beyond;
    end

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_coord_first        = r_out_first;
    assign o_coord_second       = r_out_second;
    assign o_coord_third        = r_out_third;
    assign o_index_beyond_count = r_out_beyond;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a beat is still in work");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("output beat raised outside the final state");

    a_beyond_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_index_beyond_count) |-> (o_coord_first == {FRAC_BITS{1'b1}}))
        else $error("first coordinate not saturated for index beyond count");

    a_digit_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> (r_base >= BASE_MIN))
        else $error("digit extraction with radix below two");

endmodule
